@@ hdl/e2q_pkg.sv @@
// Package for the Euler-to-quaternion block: CORDIC constants and fixed-point types.
// Depends on nothing; used by the lane, merge and top-level modules.
`timescale 1ns / 1ps
package e2q_pkg;
   localparam int FRAC = 30;
   localparam int IW = 34;   // CORDIC x/y width: Q2.30 plus guard bits
   localparam int ZW = 34;   // residual angle width, 2^31 = pi
   localparam logic signed [IW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [IW-1:0] trig_type;

   function automatic logic signed [ZW-1:0] atan_lut(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
         3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
         6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
         9: r = 34'sd1335087;   10: r = 34'sd667544;    11: r = 34'sd333772;
         12: r = 34'sd166886;   13: r = 34'sd83443;     14: r = 34'sd41722;
         15: r = 34'sd20861;    16: r = 34'sd10430;     17: r = 34'sd5215;
         18: r = 34'sd2608;     19: r = 34'sd1304;      20: r = 34'sd652;
         21: r = 34'sd326;      22: r = 34'sd163;       23: r = 34'sd81;
         24: r = 34'sd41;       25: r = 34'sd20;        26: r = 34'sd10;
         27: r = 34'sd5;        28: r = 34'sd3;         29: r = 34'sd1;
         30: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Round a Q2.30 x Q2.30 product back to Q2.30.
   function automatic trig_type mulq(input trig_type a, input trig_type b);
      logic signed [2*IW-1:0] p;
      logic signed [2*IW-1:0] q;
      p = a * b;
      q = (p + (68'sd1 <<< (FRAC - 1))) >>> FRAC;
      return q[IW-1:0];
   endfunction
endpackage

@@ hdl/euler_to_quaternion.sv @@
// Euler angles to quaternion: three CORDIC lanes and a product/merge pipeline.
// An item passes the lane input register, the CORDIC stages and the merge stages.
// Throughput: one item per cycle; the whole pipeline advances as one unit and
// stalls only when the output stage holds a result that is not taken.
// Reset: synchronous active high; clears the valid bits of every stage.
`timescale 1ns / 1ps
module euler_to_quaternion import e2q_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   parameter int OUT_BITS = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ANGLE_BITS-1:0] req_angle_x,
   input  logic signed [ANGLE_BITS-1:0] req_angle_y,
   input  logic signed [ANGLE_BITS-1:0] req_angle_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_BITS-1:0]   rsp_quat_w,
   output logic signed [OUT_BITS-1:0]   rsp_quat_x,
   output logic signed [OUT_BITS-1:0]   rsp_quat_y,
   output logic signed [OUT_BITS-1:0]   rsp_quat_z
);
   // lane input reg, CORDIC_STEPS stages, 4 merge stages
   localparam int DEPTH = CORDIC_STEPS + 5;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic advance;
   trig_type cx, sx, cy, sy, cz, sz;

   // advance whenever the output slot is empty or being drained
   assign advance   = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end

   e2q_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
      .clock(clock), .advance(advance), .angle(req_angle_x), .cos_out(cx), .sin_out(sx));
   e2q_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
      .clock(clock), .advance(advance), .angle(req_angle_y), .cos_out(cy), .sin_out(sy));
   e2q_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
      .clock(clock), .advance(advance), .angle(req_angle_z), .cos_out(cz), .sin_out(sz));

   e2q_merge #(.OUT_BITS(OUT_BITS)) u_merge (
      .clock(clock), .advance(advance),
      .c1(cx), .s1(sx), .c2(cy), .s2(sy), .c3(cz), .s3(sz),
      .quat_w(rsp_quat_w), .quat_x(rsp_quat_x), .quat_y(rsp_quat_y), .quat_z(rsp_quat_z));

   assign rsp_valid = vld_ff[DEPTH-1];
endmodule

@@ hdl/e2q_lane.sv @@
// One CORDIC lane: pipelined rotation-mode cosine/sine of a halved binary angle.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_lane import e2q_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                         clock,
   input  logic                         advance,
   input  logic signed [ANGLE_BITS-1:0] angle,
   output trig_type                     cos_out,
   output trig_type                     sin_out
);
   trig_type                x_ff [CORDIC_STEPS+1];
   trig_type                y_ff [CORDIC_STEPS+1];
   logic signed [ZW-1:0]    z_ff [CORDIC_STEPS+1];
   logic signed [ZW-1:0]    z_in;

   // halve with floor, then scale to 2^31 = pi
   always_comb begin
      z_in = ZW'(angle >>> 1) <<< (32 - ANGLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= z_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_lut(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_lut(i);
            end
         end
      end
   end

   assign cos_out = x_ff[CORDIC_STEPS];
   assign sin_out = y_ff[CORDIC_STEPS];
endmodule

@@ hdl/e2q_merge.sv @@
// Merge stage: pair products, third-factor products, sums, round and saturate.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_merge import e2q_pkg::*; #(
   parameter int OUT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       advance,
   input  trig_type                   c1, s1, c2, s2, c3, s3,
   output logic signed [OUT_BITS-1:0] quat_w, quat_x, quat_y, quat_z
);
   localparam int SH = FRAC - (OUT_BITS - 1);
   trig_type c1c2_ff, s1s2_ff, s1c2_ff, c1s2_ff, c3_ff, s3_ff;
   trig_type p_ff [8];
   logic signed [IW:0] sum_ff [4];
   logic signed [OUT_BITS-1:0] q_ff [4];

   function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [IW:0] v);
      logic signed [IW+1:0] r;
      logic signed [IW+1:0] hi;
      logic signed [IW+1:0] lo;
      hi = (IW+2)'((64'sd1 <<< (OUT_BITS - 1)) - 1);
      lo = -hi - 1;
      if (SH > 0) r = ((IW+2)'(v) + ((IW+2)'(1) <<< (SH - 1))) >>> SH;
      else if (SH == 0) r = (IW+2)'(v);
      else r = (IW+2)'(v) <<< 1;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r[OUT_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         c1c2_ff <= mulq(c1, c2);
         s1s2_ff <= mulq(s1, s2);
         s1c2_ff <= mulq(s1, c2);
         c1s2_ff <= mulq(c1, s2);
         c3_ff   <= c3;
         s3_ff   <= s3;
         p_ff[0] <= mulq(c1c2_ff, c3_ff);
         p_ff[1] <= mulq(s1s2_ff, s3_ff);
         p_ff[2] <= mulq(c1c2_ff, s3_ff);
         p_ff[3] <= mulq(s1s2_ff, c3_ff);
         p_ff[4] <= mulq(s1c2_ff, c3_ff);
         p_ff[5] <= mulq(c1s2_ff, s3_ff);
         p_ff[6] <= mulq(c1s2_ff, c3_ff);
         p_ff[7] <= mulq(s1c2_ff, s3_ff);
         sum_ff[0] <= (IW+1)'(p_ff[0]) - (IW+1)'(p_ff[1]);
         sum_ff[1] <= (IW+1)'(p_ff[2]) + (IW+1)'(p_ff[3]);
         sum_ff[2] <= (IW+1)'(p_ff[4]) + (IW+1)'(p_ff[5]);
         sum_ff[3] <= (IW+1)'(p_ff[6]) - (IW+1)'(p_ff[7]);
         for (int k = 0; k < 4; k++) q_ff[k] <= to_out(sum_ff[k]);
      end
   end

   assign quat_w = q_ff[0];
   assign quat_x = q_ff[1];
   assign quat_y = q_ff[2];
   assign quat_z = q_ff[3];
endmodule

@@ hdl/e2q_checker.sv @@
// Port-level checker for euler_to_quaternion, bound to the top level.
// Depends on nothing beyond the top-level ports.
`timescale 1ns / 1ps
module e2q_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped while stalled");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("input blocked with empty output");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("input taken during stall");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready));
